>>> hw/rtl/rpq_pkg.sv
// Package: shared types, constants and GF(2^8) helpers for the P/Q syndrome engine.
`timescale 1ns / 1ps
package rpq_pkg;

	localparam int MAX_DATA_DISKS = 32;
	localparam int BYTE_LANES     = 8;
	localparam int QUEUE_DEPTH    = 4;

	localparam int IDX_W   = 6;
	localparam int WORD_W  = 64;
	localparam int CFG_W   = 6;
	localparam int CIDX_W  = 2;
	localparam int S_TDATA_W = ((IDX_W + 3 * WORD_W + 7) / 8) * 8;
	localparam int M_TDATA_W = 2 * WORD_W;

	localparam logic [CIDX_W-1:0] REG_MODE       = 2'd0;
	localparam logic [CIDX_W-1:0] REG_DATA_DISKS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_FIRST_DISK = 2'd2;
	localparam logic [CIDX_W-1:0] REG_LAST_DISK  = 2'd3;

	localparam logic MODE_GENERATE = 1'b0;
	localparam logic MODE_UPDATE   = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam logic [WORD_W-1:0] LANE_MASK = (BYTE_LANES >= 8) ? {WORD_W{1'b1}} :
		((64'd1 << (8 * BYTE_LANES)) - 64'd1);

	localparam logic [7:0] GF_POLY_LOW = 8'h1d;

	localparam logic [7:0] GEN_POWERS [64] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
		8'h1d, 8'h3a, 8'h74, 8'he8, 8'hcd, 8'h87, 8'h13, 8'h26,
		8'h4c, 8'h98, 8'h2d, 8'h5a, 8'hb4, 8'h75, 8'hea, 8'hc9,
		8'h8f, 8'h03, 8'h06, 8'h0c, 8'h18, 8'h30, 8'h60, 8'hc0,
		8'h9d, 8'h27, 8'h4e, 8'h9c, 8'h25, 8'h4a, 8'h94, 8'h35,
		8'h6a, 8'hd4, 8'hb5, 8'h77, 8'hee, 8'hc1, 8'h9f, 8'h23,
		8'h46, 8'h8c, 8'h05, 8'h0a, 8'h14, 8'h28, 8'h50, 8'ha0,
		8'h5d, 8'hba, 8'h69, 8'hd2, 8'hb9, 8'h6f, 8'hde, 8'ha1
	};

	typedef struct packed {
		logic              pass;
		logic              load;
		logic              emit;
		logic [WORD_W-1:0] p_term;
		logic [WORD_W-1:0] q_term;
		logic [WORD_W-1:0] init_p;
		logic [WORD_W-1:0] init_q;
	} rpq_entry_t;

	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] c);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'h00;
		sh  = a;
		for (int i = 0; i < 8; i++) begin
			if (c[i]) begin
				acc = acc ^ sh;
			end
			sh = gf_xtime(sh);
		end
		return acc;
	endfunction

endpackage

>>> hw/rtl/rpq_front.sv
// Front: configuration registers, item classification and Q-term multiply.
`timescale 1ns / 1ps
module rpq_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rpq_pkg::CIDX_W-1:0] cfg_index,
	input  logic [rpq_pkg::CFG_W-1:0]  cfg_data,
	input  logic [rpq_pkg::IDX_W-1:0]  disk_index,
	input  logic [rpq_pkg::WORD_W-1:0] data_word,
	input  logic [rpq_pkg::WORD_W-1:0] old_p,
	input  logic [rpq_pkg::WORD_W-1:0] old_q,
	output logic                       keep,
	output rpq_pkg::rpq_entry_t        entry
);
	import rpq_pkg::*;

	logic             mode_q;
	logic [CFG_W-1:0] data_disks_q;
	logic [CFG_W-1:0] first_disk_q;
	logic [CFG_W-1:0] last_disk_q;

	logic              cfg_bad;
	logic [IDX_W-1:0]  lo;
	logic [IDX_W-1:0]  hi;
	logic [WORD_W-1:0] d_m;
	logic [WORD_W-1:0] op_m;
	logic [WORD_W-1:0] oq_m;
	logic [WORD_W-1:0] qd;
	logic [7:0]        coef;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_GENERATE;
			data_disks_q <= CFG_W'(1);
			first_disk_q <= '0;
			last_disk_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:       mode_q       <= cfg_data[0];
				REG_DATA_DISKS: data_disks_q <= cfg_data;
				REG_FIRST_DISK: first_disk_q <= cfg_data;
				REG_LAST_DISK:  last_disk_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign d_m  = data_word & LANE_MASK;
	assign op_m = old_p & LANE_MASK;
	assign oq_m = old_q & LANE_MASK;
	assign coef = GEN_POWERS[disk_index];

	always_comb begin
		qd = '0;
		for (int l = 0; l < BYTE_LANES; l++) begin
			qd[8*l +: 8] = gf_mul(d_m[8*l +: 8], coef);
		end
	end

	always_comb begin
		cfg_bad = (data_disks_q == '0) || ({1'b0, data_disks_q} > 7'(MAX_DATA_DISKS));
		if (mode_q == MODE_UPDATE) begin
			cfg_bad = cfg_bad || (first_disk_q > last_disk_q) ||
				(last_disk_q >= data_disks_q);
		end
		lo = (mode_q == MODE_UPDATE) ? first_disk_q : '0;
		hi = (mode_q == MODE_UPDATE) ? last_disk_q : data_disks_q - CFG_W'(1);
	end

	always_comb begin
		entry.pass   = cfg_bad;
		entry.load   = (disk_index == lo);
		entry.emit   = cfg_bad || (disk_index == hi);
		entry.p_term = d_m;
		entry.q_term = qd;
		entry.init_p = (cfg_bad || mode_q == MODE_UPDATE) ? op_m : '0;
		entry.init_q = (cfg_bad || mode_q == MODE_UPDATE) ? oq_m : '0;
		keep = cfg_bad || ((disk_index >= lo) && (disk_index <= hi));
	end

endmodule

>>> hw/rtl/rpq_queue.sv
// Queue: short FIFO of classified entries between front and back.
`timescale 1ns / 1ps
module rpq_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rpq_pkg::rpq_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output rpq_pkg::rpq_entry_t head
);
	import rpq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	rpq_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

>>> hw/rtl/rpq_back.sv
// Back: P/Q accumulators and the result output register.
`timescale 1ns / 1ps
module rpq_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       avail,
	input  rpq_pkg::rpq_entry_t        head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rpq_pkg::WORD_W-1:0] p_word,
	output logic [rpq_pkg::WORD_W-1:0] q_word,
	output logic                       status
);
	import rpq_pkg::*;

	logic [WORD_W-1:0] p_acc_q;
	logic [WORD_W-1:0] q_acc_q;
	logic [WORD_W-1:0] p_res_q;
	logic [WORD_W-1:0] q_res_q;
	logic              status_q;
	logic              valid_q;
	logic              slot_free;
	logic [WORD_W-1:0] p_next;
	logic [WORD_W-1:0] q_next;

	assign slot_free = !valid_q || out_ready;
	assign pop       = avail && (!head.emit || slot_free);
	assign p_next    = (head.load ? head.init_p : p_acc_q) ^ head.p_term;
	assign q_next    = (head.load ? head.init_q : q_acc_q) ^ head.q_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_acc_q <= '0;
			q_acc_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop && !head.pass) begin
				p_acc_q <= p_next;
				q_acc_q <= q_next;
			end
			if (pop && head.emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.emit) begin
			p_res_q  <= head.pass ? head.init_p : p_next;
			q_res_q  <= head.pass ? head.init_q : q_next;
			status_q <= head.pass ? STATUS_BAD : STATUS_OK;
		end
	end

	assign out_valid = valid_q;
	assign p_word    = p_res_q;
	assign q_word    = q_res_q;
	assign status    = status_q;

endmodule

>>> hw/rtl/raid6_pq_syndrome_engine_unit.sv
// Top level: RAID-6 P/Q syndrome engine over GF(2^8), eight byte lanes.
//
//  channel  | direction | fields
//  s_axis   | in        | tdata: disk_index, data_word, old_p, old_q
//  m_axis   | out       | tdata: p_word, q_word; tuser: status
//  cfg      | in        | cfg_index, cfg_data (mode, data_disks, first_disk, last_disk)
//
// One item per cycle unless the queue is full; results pass the queue and the output register.
// The front classifies and multiplies by alpha^index in the accept cycle, the back adds one
// queued entry per cycle unless a final one awaits the output slot; the accumulator loop sets the rate.
// A four-entry queue holds items while the output register waits on m_axis_tready.
// arst_n resets the configuration to defaults and clears the accumulators, queue and output valid.
`timescale 1ns / 1ps
module raid6_pq_syndrome_engine_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// disk_index[5:0], data_word[69:6], old_p[133:70], old_q[197:134], zero fill
	input  logic [rpq_pkg::S_TDATA_W-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// p_word[63:0], q_word[127:64]
	output logic [rpq_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status[0]
	output logic                          m_axis_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rpq_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [rpq_pkg::CFG_W-1:0]     cfg_data
);
	import rpq_pkg::*;

	logic              keep;
	logic              q_full;
	logic              q_avail;
	logic              q_pop;
	logic              s_xfer;
	rpq_entry_t        f_entry;
	rpq_entry_t        q_head;
	logic [WORD_W-1:0] p_word;
	logic [WORD_W-1:0] q_word;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	rpq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.disk_index (s_axis_tdata[IDX_W-1:0]),
		.data_word  (s_axis_tdata[IDX_W +: WORD_W]),
		.old_p      (s_axis_tdata[IDX_W + WORD_W +: WORD_W]),
		.old_q      (s_axis_tdata[IDX_W + 2*WORD_W +: WORD_W]),
		.keep       (keep),
		.entry      (f_entry)
	);

	rpq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_xfer && keep),
		.push_entry (f_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_avail),
		.head       (q_head)
	);

	rpq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (q_avail),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.p_word    (p_word),
		.q_word    (q_word),
		.status    (m_axis_tuser)
	);

	assign m_axis_tdata = {q_word, p_word};

endmodule

>>> hw/rtl/rpq_checker.sv
// Checker: port-level assertions for the P/Q syndrome engine, bound to the top level.
`timescale 1ns / 1ps
module rpq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [rpq_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("m_axis_tvalid dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("m_axis payload changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output stall");

endmodule

bind raid6_pq_syndrome_engine_unit rpq_checker u_rpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> dv/raid6_pq_syndrome_engine_unit_test.sv
// Testbench for the RAID-6 P/Q syndrome engine: directed and random columns vs a predictor.
`timescale 1ns / 1ps
module raid6_pq_syndrome_engine_unit_test;
	import rpq_pkg::*;

	localparam int RANDOM_ITEMS  = 1650;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 500000;

	typedef struct packed {
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] q;
		logic              status;
	} parity_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CIDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	parity_t           pending_parity[$];
	logic              cfg_mode;
	logic [CFG_W-1:0]  cfg_disks;
	logic [CFG_W-1:0]  cfg_first;
	logic [CFG_W-1:0]  cfg_last;
	logic [WORD_W-1:0] p_acc;
	logic [WORD_W-1:0] q_acc;
	int                errors = 0;
	int                items_used = 0;
	int                cycle_count = 0;
	bit                no_idle = 1'b0;

	raid6_pq_syndrome_engine_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_parity.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int draw_gap();
		if (no_idle) begin
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic logic [WORD_W-1:0] draw_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'h8080_8080_8080_8080;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// GF(2^8) multiply of every byte lane by alpha^e, field polynomial 0x11d
	function automatic logic [WORD_W-1:0] scale_by_alpha(input logic [WORD_W-1:0] w,
		input int e);
		logic [7:0] b;
		for (int n = 0; n < e; n++) begin
			for (int l = 0; l < 8; l++) begin
				b = w[8*l +: 8];
				w[8*l +: 8] = {b[6:0], 1'b0} ^ (b[7] ? 8'h1d : 8'h00);
			end
		end
		return w;
	endfunction

	function automatic bit config_invalid();
		if (cfg_disks < 1 || cfg_disks > MAX_DATA_DISKS) begin
			return 1'b1;
		end
		if (cfg_mode == MODE_UPDATE && (cfg_first > cfg_last || cfg_last >= cfg_disks)) begin
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// returns 1 when the item is not ignored by the engine
	function automatic bit predict_column(input logic [IDX_W-1:0] idx,
		input logic [WORD_W-1:0] dw, input logic [WORD_W-1:0] op,
		input logic [WORD_W-1:0] oq);
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] q;
		parity_t           r;
		if (config_invalid()) begin
			r.p = op & LANE_MASK;
			r.q = oq & LANE_MASK;
			r.status = STATUS_BAD;
			pending_parity.push_back(r);
			return 1'b1;
		end
		lo = (cfg_mode == MODE_UPDATE) ? cfg_first : '0;
		hi = (cfg_mode == MODE_UPDATE) ? cfg_last : cfg_disks - CFG_W'(1);
		if (idx < lo || idx > hi) begin
			return 1'b0;
		end
		if (idx == lo) begin
			p = (cfg_mode == MODE_UPDATE) ? (op & LANE_MASK) : '0;
			q = (cfg_mode == MODE_UPDATE) ? (oq & LANE_MASK) : '0;
		end else begin
			p = p_acc;
			q = q_acc;
		end
		p_acc = (p ^ (dw & LANE_MASK)) & LANE_MASK;
		q_acc = (q ^ scale_by_alpha(dw & LANE_MASK, idx)) & LANE_MASK;
		if (idx == hi) begin
			r.p = p_acc;
			r.q = q_acc;
			r.status = STATUS_OK;
			pending_parity.push_back(r);
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
		input logic [WORD_W-1:0] want);
		$display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_item(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] dw,
		input logic [WORD_W-1:0] op, input logic [WORD_W-1:0] oq);
		int                   gap;
		logic [S_TDATA_W-1:0] word;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word = '0;
		word[IDX_W + 3*WORD_W - 1:0] = {oq, op, dw, idx};
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
		if (predict_column(idx, dw, op, oq)) begin
			items_used++;
		end
	endtask

	task automatic send_random(input logic [IDX_W-1:0] idx);
		send_item(idx, draw_word(), draw_word(), draw_word());
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:       cfg_mode  = val[0];
			REG_DATA_DISKS: cfg_disks = val;
			REG_FIRST_DISK: cfg_first = val;
			REG_LAST_DISK:  cfg_last  = val;
			default: ;
		endcase
	endtask

	// hold until every result is back and the engine has drained
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_parity.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic m, input logic [CFG_W-1:0] disks,
		input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] last);
		settle();
		write_reg(REG_MODE, {5'($urandom_range(0, 31)), m});
		write_reg(REG_DATA_DISKS, disks);
		write_reg(REG_FIRST_DISK, first);
		write_reg(REG_LAST_DISK, last);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_item(6'd0, '1, draw_word(), draw_word());
		send_item(6'd63, 64'h5555_5555_5555_5555, '1, '1);
		send_item(6'd0, 64'h8080_8080_8080_8080, '0, '0);
	endtask

	task automatic test_generate_column();
		configure(MODE_GENERATE, 6'd4, 6'd0, 6'd0);
		send_item(6'd0, 64'h8080_8080_8080_8080, '1, '1);
		send_item(6'd1, '1, '0, '0);
		send_item(6'd2, '0, '1, '1);
		send_random(6'd3);
		// range start missing: accumulation carries on
		send_random(6'd1);
		send_random(6'd2);
		send_random(6'd3);
	endtask

	task automatic test_update_range();
		configure(MODE_UPDATE, 6'd4, 6'd2, 6'd2);
		send_item(6'd2, draw_word(), '1, '1);
		send_random(6'd1);
		send_random(6'd3);
		configure(MODE_UPDATE, 6'd4, 6'd1, 6'd3);
		send_random(6'd1);
		send_random(6'd2);
		send_random(6'd3);
		configure(MODE_UPDATE, 6'd32, 6'd31, 6'd31);
		send_item(6'd31, '1, draw_word(), draw_word());
	endtask

	task automatic test_bad_config();
		configure(MODE_GENERATE, 6'd0, 6'd0, 6'd0);
		send_item(6'd63, '1, '1, '1);
		send_random(6'd0);
		configure(MODE_GENERATE, 6'd33, 6'd0, 6'd0);
		send_random(6'd5);
		configure(MODE_GENERATE, 6'd63, 6'd63, 6'd63);
		send_random(6'd40);
		configure(MODE_UPDATE, 6'd8, 6'd5, 6'd3);
		send_random(6'd4);
		configure(MODE_UPDATE, 6'd8, 6'd2, 6'd8);
		send_random(6'd2);
	endtask

	task automatic test_random_columns();
		logic m;
		int   disks;
		int   first;
		int   last;
		int   lo;
		int   hi;
		int   cols;
		int   shape;
		while (items_used < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: disks = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
				1, 2: disks = MAX_DATA_DISKS;
				3, 4, 5, 6: disks = $urandom_range(1, 4);
				default: disks = $urandom_range(1, MAX_DATA_DISKS);
			endcase
			m = 1'($urandom_range(0, 1));
			if (disks >= 1 && disks <= MAX_DATA_DISKS && $urandom_range(0, 9) != 0) begin
				first = $urandom_range(0, disks - 1);
				last  = $urandom_range(first, disks - 1);
			end else begin
				first = $urandom_range(0, 63);
				last  = $urandom_range(0, 63);
			end
			configure(m, CFG_W'(disks), CFG_W'(first), CFG_W'(last));
			no_idle = ($urandom_range(0, 3) == 0);
			cols = $urandom_range(2, 8);
			repeat (cols) begin
				if (config_invalid()) begin
					repeat ($urandom_range(1, 4)) send_random(6'($urandom_range(0, 63)));
				end else begin
					lo = (m == MODE_UPDATE) ? first : 0;
					hi = (m == MODE_UPDATE) ? last : disks - 1;
					shape = $urandom_range(0, 9);
					if (shape == 9) begin
						repeat ($urandom_range(1, 4)) send_random(6'($urandom_range(0, 63)));
					end else begin
						for (int i = lo; i <= hi; i++) begin
							if (shape == 8 && $urandom_range(0, 2) == 0) begin
								send_random(6'($urandom_range(0, 63)));
							end
							if (shape != 7 || $urandom_range(0, 3) != 0) begin
								send_random(6'(i));
							end
						end
					end
				end
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			int gap;
			gap = draw_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		parity_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_parity.size() == 0) begin
				report_mismatch("unexpected transfer p_word", m_axis_tdata[WORD_W-1:0], '0);
			end else begin
				want = pending_parity.pop_front();
				if (m_axis_tdata[WORD_W-1:0] !== want.p) begin
					report_mismatch("p_word", m_axis_tdata[WORD_W-1:0], want.p);
				end
				if (m_axis_tdata[2*WORD_W-1:WORD_W] !== want.q) begin
					report_mismatch("q_word", m_axis_tdata[2*WORD_W-1:WORD_W], want.q);
				end
				if (m_axis_tuser !== want.status) begin
					report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
				end
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_mode  = MODE_GENERATE;
		cfg_disks = 6'd1;
		cfg_first = '0;
		cfg_last  = '0;
		p_acc     = '0;
		q_acc     = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_generate_column();
		test_update_range();
		test_bad_config();
		items_used = 0;
		test_random_columns();
		settle();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/rpq_pkg.sv
hw/rtl/rpq_front.sv
hw/rtl/rpq_queue.sv
hw/rtl/rpq_back.sv
hw/rtl/raid6_pq_syndrome_engine_unit.sv
hw/rtl/rpq_checker.sv
dv/raid6_pq_syndrome_engine_unit_test.sv
